[hdl/ntcbt_pkg.sv]
// constants and register indexes shared by the ntc beta temperature block
`default_nettype none
package ntcbt_pkg;

   localparam int LN_IN_W   = 20;   // widest logarithm operand (resistor registers)
   localparam int MANT_W    = 31;   // q30 mantissa in [1, 2)
   localparam int FRAC_W    = 24;   // log2 fraction bits, one per squaring step
   localparam int EXP_W     = 5;
   localparam int LN_W      = 21;   // ln result in q5.16, never negative here
   localparam int LANES     = 4;    // code, fs - code, series, nominal
   localparam int L_W       = 24;   // signed sum of logarithms
   localparam int B100_W    = 21;
   localparam int T0_W      = 16;
   localparam int NUM_W     = 53;
   localparam int DEN_W     = 42;
   localparam int DPOS_W    = 41;
   localparam int REM_W     = 54;
   localparam int CMP_W     = 59;
   localparam int QUO_W     = 18;

   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam logic [19:0] LN_CLAMP_Q16 = 20'd905413;
   localparam int          KELVIN_CENTI = 27315;
   localparam int          TEMP_MIN     = -5500;
   localparam int          TEMP_MAX     = 25000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_SERIES_OHMS  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOMINAL_OHMS = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BETA_KELVIN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOMINAL_TEMP = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_NTC_TO_GND   = 3'd4;

   localparam logic [19:0] RST_SERIES_OHMS  = 20'd10000;
   localparam logic [19:0] RST_NOMINAL_OHMS = 20'd10000;
   localparam logic [13:0] RST_BETA_KELVIN  = 14'd3950;
   localparam logic [14:0] RST_NOMINAL_TEMP = 15'd2500;

endpackage
`default_nettype wire

[hdl/ntc_beta_temperature.sv]
// ntc thermistor beta equation temperature converter, fixed point pipeline
// 49 register stages lie between the input transfer edge and result valid
// throughput: one item per cycle; every stage is a register, the whole pipe
//   halts together only while the result register is full and not taken
// reset (synchronous, active high) empties the pipe and loads the default
//   register values: 10k series, 10k nominal, beta 3950, 25.00 C, ntc to ground
`default_nettype none
module ntc_beta_temperature #(
   parameter int ADC_BITS = 12,
   parameter int CHANNELS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   // input stream
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((ADC_BITS+7)/8)*8-1:0]          req_tdata,  // adc_code, zero pad
   input  wire logic [((CHANNELS>1)?$clog2(CHANNELS):1)-1:0] req_tuser, // channel
   // result stream
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [15:0]                                 rsp_tdata,  // temp_centi
   output logic [((CHANNELS>1)?$clog2(CHANNELS):1):0]  rsp_tuser,  // channel_out, saturated
   // register write port
   input  wire logic                                   csr_we,
   input  wire logic [ntcbt_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [ntcbt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LAT    = 49;
   localparam int FLG_N  = 27;   // code flags needed up to the combine stage
   localparam int NSQ    = ntcbt_pkg::FRAC_W;
   localparam int NDIV   = ntcbt_pkg::QUO_W;
   localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [19:0] series_ff, nominal_ff;
   logic [13:0] beta_ff;
   logic [14:0] t_nom_ff;
   logic        to_gnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= ntcbt_pkg::RST_SERIES_OHMS;
         nominal_ff <= ntcbt_pkg::RST_NOMINAL_OHMS;
         beta_ff    <= ntcbt_pkg::RST_BETA_KELVIN;
         t_nom_ff   <= ntcbt_pkg::RST_NOMINAL_TEMP;
         to_gnd_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            ntcbt_pkg::CSR_SERIES_OHMS:  series_ff  <= csr_wdata[19:0];
            ntcbt_pkg::CSR_NOMINAL_OHMS: nominal_ff <= csr_wdata[19:0];
            ntcbt_pkg::CSR_BETA_KELVIN:  beta_ff    <= csr_wdata[13:0];
            ntcbt_pkg::CSR_NOMINAL_TEMP: t_nom_ff   <= csr_wdata[14:0];
            ntcbt_pkg::CSR_NTC_TO_GND:   to_gnd_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // derived constants of the configuration, stable long before any item uses them
   // b100 = 100 * beta (zero beta taken as one), t0 = nominal temp in 0.01 K
   logic [ntcbt_pkg::B100_W-1:0] b100_ff, b100_in;
   logic [ntcbt_pkg::T0_W-1:0]   t0_ff, t0_in;
   logic [16:0]                  t0_wide;

   always_comb begin
      b100_in = ntcbt_pkg::B100_W'((beta_ff == 14'd0) ? 14'd1 : beta_ff)
                * ntcbt_pkg::B100_W'(100);
      t0_wide = 17'($signed({{2{t_nom_ff[14]}}, t_nom_ff}) + 17'sd27315);
      t0_in   = t0_wide[ntcbt_pkg::T0_W-1:0];
   end

   always_ff @(posedge clock) begin
      b100_ff <= b100_in;
      t0_ff   <= t0_in;
   end

   // ---------------------------------------------------------------------
   // pipeline control: every stage moves together
   // ---------------------------------------------------------------------
   logic           adv;
   logic [LAT-1:0] v_ff;

   assign adv        = !v_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAT-2:0], req_tvalid};
      end
   end

   // channel and code flags ride along with the item
   logic [CH_W-1:0]  ch_ff [0:LAT-1];
   logic [FLG_N-1:0] zero_ff, full_ff;   // code at zero / at full scale
   logic [ADC_BITS-1:0] code_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         code_ff    <= req_tdata[ADC_BITS-1:0];
         ch_ff[0]   <= req_tuser;
         zero_ff    <= {zero_ff[FLG_N-2:0], (req_tdata[ADC_BITS-1:0] == '0)};
         full_ff    <= {full_ff[FLG_N-2:0], (req_tdata[ADC_BITS-1:0] == FS)};
         for (int i = 1; i < LAT; i++) ch_ff[i] <= ch_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // logarithm lanes: normalize, 24 squaring stages, scale by ln2
   // ---------------------------------------------------------------------
   logic [ntcbt_pkg::MANT_W-1:0] m_ff    [0:NSQ][0:ntcbt_pkg::LANES-1];
   logic [ntcbt_pkg::FRAC_W-1:0] frac_ff [0:NSQ][0:ntcbt_pkg::LANES-1];
   logic [ntcbt_pkg::EXP_W-1:0]  exp_ff  [0:NSQ][0:ntcbt_pkg::LANES-1];

   function automatic logic [ntcbt_pkg::EXP_W-1:0] msb_pos(
      input logic [ntcbt_pkg::LN_IN_W-1:0] n);
      logic [ntcbt_pkg::EXP_W-1:0] p;
      p = '0;
      for (int i = 0; i < ntcbt_pkg::LN_IN_W; i++) begin
         if (n[i]) p = ntcbt_pkg::EXP_W'(i);
      end
      return p;
   endfunction

   // lane operands, zero replaced by one
   logic [ntcbt_pkg::LN_IN_W-1:0] op_n [0:ntcbt_pkg::LANES-1];

   always_comb begin
      op_n[0] = zero_ff[0] ? ntcbt_pkg::LN_IN_W'(1) : ntcbt_pkg::LN_IN_W'(code_ff);
      op_n[1] = full_ff[0] ? ntcbt_pkg::LN_IN_W'(1) : ntcbt_pkg::LN_IN_W'(FS - code_ff);
      op_n[2] = (series_ff  == '0) ? ntcbt_pkg::LN_IN_W'(1) : series_ff;
      op_n[3] = (nominal_ff == '0) ? ntcbt_pkg::LN_IN_W'(1) : nominal_ff;
   end

   genvar gl, gk;
   generate
      for (gl = 0; gl < ntcbt_pkg::LANES; gl++) begin : g_norm
         logic [ntcbt_pkg::EXP_W-1:0] e_in;
         always_comb e_in = msb_pos(op_n[gl]);
         always_ff @(posedge clock) begin
            if (adv) begin
               exp_ff[0][gl]  <= e_in;
               m_ff[0][gl]    <= ntcbt_pkg::MANT_W'(op_n[gl]) << (5'd30 - e_in);
               frac_ff[0][gl] <= '0;
            end
         end
      end

      for (gk = 1; gk <= NSQ; gk++) begin : g_sq
         for (gl = 0; gl < ntcbt_pkg::LANES; gl++) begin : g_lane
            logic [61:0] sq;
            logic [31:0] t;
            logic [ntcbt_pkg::MANT_W-1:0] m_in;
            logic [ntcbt_pkg::FRAC_W-1:0] frac_in;
            always_comb begin
               sq      = 62'(m_ff[gk-1][gl]) * 62'(m_ff[gk-1][gl]);
               t       = sq[61:30];
               frac_in = frac_ff[gk-1][gl];
               frac_in[NSQ-gk] = t[31];
               m_in    = t[31] ? t[31:1] : t[30:0];
            end
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[gk][gl]    <= m_in;
                  frac_ff[gk][gl] <= frac_in;
                  exp_ff[gk][gl]  <= exp_ff[gk-1][gl];
               end
            end
         end
      end
   endgenerate

   // ln = round(log2 * ln2) in q5.16
   function automatic logic [ntcbt_pkg::LN_W-1:0] ln_scale(input logic [28:0] l2);
      logic [61:0] p;
      p = 62'(l2) * 62'(ntcbt_pkg::LN2_Q32) + (62'(1) << 39);
      return p[60:40];
   endfunction

   logic [ntcbt_pkg::LN_W-1:0] ln_ff [0:ntcbt_pkg::LANES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < ntcbt_pkg::LANES; j++) begin
            ln_ff[j] <= ln_scale({exp_ff[NSQ][j], frac_ff[NSQ][j]});
         end
      end
   end

   // ---------------------------------------------------------------------
   // combine: l = ln(rs) - ln(r0) +/- ln(x / (1 - x))
   // ---------------------------------------------------------------------
   logic signed [ntcbt_pkg::L_W-1:0] l_ff, l_in, lr;

   always_comb begin
      if (zero_ff[FLG_N-1]) begin
         lr = -$signed({4'b0, ntcbt_pkg::LN_CLAMP_Q16});
      end else if (full_ff[FLG_N-1]) begin
         lr = $signed({4'b0, ntcbt_pkg::LN_CLAMP_Q16});
      end else begin
         lr = $signed({3'b0, ln_ff[0]}) - $signed({3'b0, ln_ff[1]});
      end
      if (!to_gnd_ff) lr = -lr;
      l_in = $signed({3'b0, ln_ff[2]}) - $signed({3'b0, ln_ff[3]}) + lr;
   end

   always_ff @(posedge clock) begin
      if (adv) l_ff <= l_in;
   end

   // ---------------------------------------------------------------------
   // numerator and denominator of the beta equation
   // ---------------------------------------------------------------------
   logic [ntcbt_pkg::NUM_W-1:0]        num_ff;
   logic signed [ntcbt_pkg::DEN_W-1:0] den_ff, den_in;
   logic signed [40:0]                 lt;
   logic [36:0]                        bt;

   always_comb begin
      lt     = l_ff * $signed({1'b0, t0_ff});
      bt     = 37'(b100_ff) * 37'(t0_ff);
      den_in = $signed({5'b0, b100_ff, 16'b0}) + ntcbt_pkg::DEN_W'(lt);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= {bt, 16'b0};
         den_ff <= den_in;
      end
   end

   // ---------------------------------------------------------------------
   // rounding offset, then restoring division one quotient bit a stage
   // ---------------------------------------------------------------------
   logic [ntcbt_pkg::REM_W-1:0]  rem_ff [0:NDIV];
   logic [ntcbt_pkg::QUO_W-1:0]  q_ff   [0:NDIV];
   logic [ntcbt_pkg::DPOS_W-1:0] d_ff   [0:NDIV];
   logic [NDIV:0]                dz_ff, dn_ff;  // denominator zero / negative

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= ntcbt_pkg::REM_W'(num_ff)
                      + ntcbt_pkg::REM_W'(den_ff[ntcbt_pkg::DEN_W-2:1]);
         d_ff[0]   <= den_ff[ntcbt_pkg::DPOS_W-1:0];
         q_ff[0]   <= '0;
         dz_ff[0]  <= (den_ff == '0);
         dn_ff[0]  <= den_ff[ntcbt_pkg::DEN_W-1];
      end
   end

   genvar gd;
   generate
      for (gd = 1; gd <= NDIV; gd++) begin : g_div
         logic [ntcbt_pkg::CMP_W-1:0] sh, r;
         logic                        take;
         logic [ntcbt_pkg::QUO_W-1:0] q_in;
         always_comb begin
            sh   = ntcbt_pkg::CMP_W'(d_ff[gd-1]) << (NDIV - gd);
            r    = ntcbt_pkg::CMP_W'(rem_ff[gd-1]);
            take = (r >= sh);
            q_in = q_ff[gd-1];
            q_in[NDIV-gd] = take;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[gd] <= take ? ntcbt_pkg::REM_W'(r - sh) : rem_ff[gd-1];
               q_ff[gd]   <= q_in;
               d_ff[gd]   <= d_ff[gd-1];
               dz_ff[gd]  <= dz_ff[gd-1];
               dn_ff[gd]  <= dn_ff[gd-1];
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------------
   // kelvin to celsius, saturation, result register
   // ---------------------------------------------------------------------
   logic [15:0] temp_ff, temp_in;
   logic        sat_ff, sat_in;
   logic [ntcbt_pkg::QUO_W-1:0] kq;
   logic [17:0] tdiff;

   always_comb begin
      kq     = q_ff[NDIV];
      tdiff  = kq - 18'(ntcbt_pkg::KELVIN_CENTI);
      sat_in = 1'b1;
      temp_in = tdiff[15:0];
      if (dz_ff[NDIV]) begin
         temp_in = 16'(ntcbt_pkg::TEMP_MAX);
      end else if (dn_ff[NDIV]) begin
         temp_in = 16'(ntcbt_pkg::TEMP_MIN);
      end else if (kq[ntcbt_pkg::QUO_W-1] ||
                   kq > 18'(ntcbt_pkg::TEMP_MAX + ntcbt_pkg::KELVIN_CENTI)) begin
         temp_in = 16'(ntcbt_pkg::TEMP_MAX);
      end else if (kq < 18'(ntcbt_pkg::TEMP_MIN + ntcbt_pkg::KELVIN_CENTI)) begin
         temp_in = 16'(ntcbt_pkg::TEMP_MIN);
      end else begin
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         temp_ff <= temp_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tdata = temp_ff;
   assign rsp_tuser = {sat_ff, ch_ff[LAT-1]};

endmodule
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the ntc beta temperature converter
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [11:0] code;
      logic [1:0]  chan;
   } sample_type;

   typedef struct {
      logic signed [15:0] temp;
      logic [1:0]         chan;
      logic               sat;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // adc_code, zero pad
   logic [1:0]  req_tuser  = '0;   // channel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // temp_centi
   logic [2:0]  rsp_tuser;         // channel_out, saturated
   logic                             csr_we    = 1'b0;
   logic [ntcbt_pkg::CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [ntcbt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ntc_beta_temperature dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // local copy of the register file
   logic [19:0]        m_series  = ntcbt_pkg::RST_SERIES_OHMS;
   logic [19:0]        m_nominal = ntcbt_pkg::RST_NOMINAL_OHMS;
   logic [13:0]        m_beta    = ntcbt_pkg::RST_BETA_KELVIN;
   logic signed [14:0] m_t0      = ntcbt_pkg::RST_NOMINAL_TEMP;
   logic               m_to_gnd  = 1'b1;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   int  errors    = 0;
   bit  no_idle   = 1'b0;   // phase-wide switch for back-to-back traffic
   bit  long_hold = 1'b0;   // request a long receiver stall

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // ln(n) in q16.16 via a q24 log2 built from 24 squaring steps
   function automatic longint ln_q16(input logic [31:0] n);
      int e;
      longint unsigned m, l2;
      e = 0;
      if (n == 0) n = 1;
      while (e < 31 && (n >> (e + 1)) != 0) e++;
      m  = longint'(n) << (30 - e);
      l2 = longint'(e) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m  = m >> 1;
            l2 = l2 | (64'd1 << i);
         end
      end
      return longint'((l2 * 64'd2977044472 + (64'd1 << 39)) >> 40);
   endfunction

   function automatic reading_type thermistor_reading(input sample_type s);
      reading_type r;
      longint lr, l, num, den, tc, b, t0c;
      logic [31:0] rs, r0;
      rs  = (m_series  == 0) ? 32'd1 : 32'(m_series);
      r0  = (m_nominal == 0) ? 32'd1 : 32'(m_nominal);
      b   = (m_beta == 0) ? 64'sd1 : longint'(m_beta);
      t0c = longint'(m_t0) + 27315;
      if (s.code == 12'd0)         lr = -905413;
      else if (s.code == 12'hFFF)  lr = 905413;
      else lr = ln_q16(32'(s.code)) - ln_q16(32'(12'hFFF - s.code));
      if (!m_to_gnd) lr = -lr;
      l   = ln_q16(rs) - ln_q16(r0) + lr;
      num = 100 * b * t0c * 65536;
      den = 100 * b * 65536 + l * t0c;
      r.sat = 1'b0;
      if (den == 0) begin
         tc = 25000; r.sat = 1'b1;
      end else if (den < 0) begin
         tc = -5500; r.sat = 1'b1;
      end else begin
         tc = (num + den / 2) / den - 27315;
         if (tc > 25000) begin
            tc = 25000; r.sat = 1'b1;
         end else if (tc < -5500) begin
            tc = -5500; r.sat = 1'b1;
         end
      end
      r.temp = tc[15:0];
      r.chan = s.chan;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 88) return $urandom_range(0, 2);
      return $urandom_range(8, 40);
   endfunction

   // ---------------- input side driver ----------------
   int  send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // a transfer: predict it from the item on the bus
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(thermistor_reading(pending_samples[0]));
            void'(pending_samples.pop_front());
            send_gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {4'd0, pending_samples[0].code};
               req_tuser  <= pending_samples[0].chan;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result side: ready pattern and checker ----------------
   int  recv_gap  = 0;
   int  hold_left = 0;
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected result transfer temp_centi=%0d", $signed(rsp_tdata));
               errors++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata !== want.temp) begin
                  $error("temp_centi expected %0d actual %0d", want.temp, $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tuser[1:0] !== want.chan) begin
                  $error("channel_out expected %0d actual %0d", want.chan, rsp_tuser[1:0]);
                  errors++;
               end
               if (rsp_tuser[2] !== want.sat) begin
                  $error("saturated expected %0d actual %0d", want.sat, rsp_tuser[2]);
                  errors++;
               end
            end
         end
         // long hold-off so the pipe fills and stalls its input
         if (long_hold && hold_left == 0) begin
            hold_left = 300;
            long_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0) recv_gap = gap_len();
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic cfg_write(input logic [ntcbt_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [19:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         ntcbt_pkg::CSR_SERIES_OHMS:  m_series  = val;
         ntcbt_pkg::CSR_NOMINAL_OHMS: m_nominal = val;
         ntcbt_pkg::CSR_BETA_KELVIN:  m_beta    = val[13:0];
         ntcbt_pkg::CSR_NOMINAL_TEMP: m_t0      = val[14:0];
         ntcbt_pkg::CSR_NTC_TO_GND:   m_to_gnd  = val[0];
         default: ;
      endcase
   endtask

   task automatic cfg_all(input logic [19:0] rs, input logic [19:0] r0,
                          input logic [19:0] b, input logic [19:0] t0, input logic [19:0] gnd);
      cfg_write(ntcbt_pkg::CSR_SERIES_OHMS, rs);
      cfg_write(ntcbt_pkg::CSR_NOMINAL_OHMS, r0);
      cfg_write(ntcbt_pkg::CSR_BETA_KELVIN, b);
      cfg_write(ntcbt_pkg::CSR_NOMINAL_TEMP, t0);
      cfg_write(ntcbt_pkg::CSR_NTC_TO_GND, gnd);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_sample(input logic [11:0] code, input logic [1:0] chan);
      sample_type s;
      s.code = code;
      s.chan = chan;
      pending_samples.push_back(s);
   endtask

   // wait until the pipe is empty, then let the latency drain
   task automatic drain();
      while (pending_samples.size() != 0 || expected_readings.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      logic [11:0] c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: code extremes, clamp ends and all channels at reset settings
      push_sample(12'd0, 2'd0);     push_sample(12'hFFF, 2'd1);
      push_sample(12'd1, 2'd2);     push_sample(12'hFFE, 2'd3);
      push_sample(12'd2048, 2'd0);  push_sample(12'd2047, 2'd1);
      push_sample(12'hAAA, 2'd2);   push_sample(12'h555, 2'd3);
      drain();
      // thermistor to reference, zero resistor and beta registers taken as one
      cfg_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
      push_sample(12'd0, 2'd0);     push_sample(12'hFFF, 2'd3);
      push_sample(12'd1234, 2'd1);  push_sample(12'd3000, 2'd2);
      drain();
      // register extremes, full field widths, denominator near zero or below
      cfg_all(20'hFFFFF, 20'd1, 20'd10000, 20'(15000), 20'd1);
      push_sample(12'd0, 2'd1);     push_sample(12'hFFF, 2'd2);
      push_sample(12'd100, 2'd0);   push_sample(12'd4000, 2'd3);
      drain();
      cfg_all(20'd1, 20'hFFFFF, 20'h3FFF, 20'h4000, 20'd0);
      push_sample(12'd0, 2'd2);     push_sample(12'hFFF, 2'd0);
      push_sample(12'd7, 2'd1);     push_sample(12'd2222, 2'd3);
      push_sample(12'd4090, 2'd3);
      drain();

      // random phases, the register setting chosen by the phase modulo four
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: cfg_all(20'd1000000, 20'd1, 20'd1000, 20'(-5500) & 20'h7FFF, 20'd1);
            1: cfg_all(20'd1, 20'd1000000, 20'd10000, 20'(15000), 20'd0);
            2: cfg_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                       20'($urandom));
            default: cfg_all(20'($urandom_range(1000, 100000)),
                             20'($urandom_range(1000, 100000)),
                             20'($urandom_range(3000, 4500)), 20'($urandom_range(0, 5000)),
                             20'($urandom_range(0, 1)));
         endcase
         no_idle = (ph % 5 == 3);
         for (int k = 0; k < 52; k++) begin
            case ($urandom_range(0, 19))
               0:       c = 12'd0;
               1:       c = 12'hFFF;
               2:       c = 12'($urandom_range(1, 8));
               3:       c = 12'($urandom_range(4087, 4094));
               default: c = 12'($urandom);
            endcase
            push_sample(c, 2'($urandom));
            if (k == 10 && ph % 3 == 1) long_hold = 1'b1;
         end
         drain();
      end

      repeat (60) @(posedge clock);
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ntcbt_pkg.sv
hdl/ntc_beta_temperature.sv
dv/testbench.sv
